// ----- hdl/locd_pkg.sv -----
// Shared types, constants and a helper function for the lock-order cycle detector.
// No dependencies; imported by the detector top level.
`default_nettype none

package locd_pkg;

    localparam int NODES   = 64;
    localparam int NODE_W  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int DEPTH_W = $clog2(NODES + 1);

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [NODES-1:0]   node_set_t;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE_RD,
        ST_EDGE_WR,
        ST_SCAN,
        ST_EXPAND,
        ST_POP_RD
    } state_t;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic node_t lowest_node(input node_set_t v);
        node_t idx;
        idx = '0;
        for (int i = NODES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = node_t'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/locd_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; used for the adjacency rows and the walk stack.
`default_nettype none

module locd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/lock_order_cycle_detector_top.sv -----
// Top level of the lock-order cycle detector: edge storage and depth-first walk.
// Depends on locd_pkg and on locd_ram for the adjacency rows and the walk stack.
//
//  Channel   Handshake               Payload
//  command   start / busy            op, from_lock, to_lock
//  result    done (one-cycle strobe) deadlock
//
// A clear command is handled in the cycle that accepts it; done rises in the cycle after.
// An edge command reads, then rewrites the source row, then walks: a scan per search tree
// root, an expand per other node pushed, an expand and a pop read per non-root pop (stack
// read, then the row re-read on the single adjacency port), an expand per root pop and a
// final scan; a hit ends the walk early. done rises in the first cycle after the last busy one.
// Reset clears the per-row valid flags at once; there is no clearing pass.
// The result is never held off: done is high for one cycle and busy is already low.
`default_nettype none

module lock_order_cycle_detector_top
    import locd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       op,
    input  wire logic [5:0] from_lock,
    input  wire logic [5:0] to_lock,
    output logic            done,
    output logic            deadlock
);

    state_t    state_reg, state_next;
    node_set_t valid_reg, valid_next;
    node_set_t visited_reg, visited_next;
    node_set_t onpath_reg, onpath_next;
    depth_t    depth_reg, depth_next;
    node_t     top_reg, top_next;
    node_t     from_reg, from_next;
    node_t     to_reg, to_next;
    logic      edge_ok_reg, edge_ok_next;
    logic      done_reg, done_next;
    logic      deadlock_reg, deadlock_next;

    logic      adj_we;
    node_t     adj_waddr;
    node_set_t adj_wdata;
    node_t     adj_raddr;
    node_set_t adj_rdata;

    logic      stk_we;
    node_t     stk_waddr;
    node_t     stk_wdata;
    node_t     stk_raddr;
    node_t     stk_rdata;

    node_set_t row;
    node_set_t cand;
    node_set_t roots;
    node_t     child;
    node_t     root;
    logic      hit;
    logic      can_push;
    logic      last_on_stack;
    depth_t    depth_less2;
    logic      accept;

    locd_ram #(
        .WIDTH(NODES),
        .DEPTH(NODES)
    ) u_adj_ram (
        .clk  (clk),
        .we   (adj_we),
        .waddr(adj_waddr),
        .wdata(adj_wdata),
        .raddr(adj_raddr),
        .rdata(adj_rdata)
    );

    locd_ram #(
        .WIDTH(NODE_W),
        .DEPTH(NODES)
    ) u_stack_ram (
        .clk  (clk),
        .we   (stk_we),
        .waddr(stk_waddr),
        .wdata(stk_wdata),
        .raddr(stk_raddr),
        .rdata(stk_rdata)
    );

    // A row that was never written since the last clear reads as empty.
    assign row           = valid_reg[top_reg] ? adj_rdata : '0;
    assign hit           = |(row & onpath_reg);
    assign cand          = row & ~visited_reg;
    assign child         = lowest_node(cand);
    assign can_push      = (cand != '0) && (depth_reg < depth_t'(NODES));
    assign roots         = valid_reg & ~visited_reg;
    assign root          = lowest_node(roots);
    assign last_on_stack = (depth_reg == depth_t'(1));
    assign depth_less2   = depth_reg - depth_t'(2);
    assign accept        = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && op == OP_ADD)
                begin
                    state_next = ST_EDGE_RD;
                end
            end
            ST_EDGE_RD:
            begin
                state_next = ST_EDGE_WR;
            end
            ST_EDGE_WR:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (roots == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EXPAND;
                end
            end
            ST_EXPAND:
            begin
                if (hit)
                begin
                    state_next = ST_IDLE;
                end
                else if (can_push)
                begin
                    state_next = ST_EXPAND;
                end
                else if (last_on_stack)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_POP_RD;
                end
            end
            ST_POP_RD:
            begin
                state_next = ST_EXPAND;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next    = valid_reg;
        visited_next  = visited_reg;
        onpath_next   = onpath_reg;
        depth_next    = depth_reg;
        top_next      = top_reg;
        from_next     = from_reg;
        to_next       = to_reg;
        edge_ok_next  = edge_ok_reg;
        done_next     = 1'b0;
        deadlock_next = 1'b0;

        adj_we    = 1'b0;
        adj_waddr = from_reg;
        adj_wdata = (valid_reg[from_reg] ? adj_rdata : '0) | (node_set_t'(1) << to_reg);
        adj_raddr = top_reg;

        stk_we    = 1'b0;
        stk_waddr = depth_reg[NODE_W-1:0];
        stk_wdata = child;
        stk_raddr = depth_less2[NODE_W-1:0];

        busy = (state_reg != ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    from_next    = node_t'(from_lock);
                    to_next      = node_t'(to_lock);
                    edge_ok_next = (int'(from_lock) < NODES) && (int'(to_lock) < NODES);
                    if (op == OP_CLEAR)
                    begin
                        valid_next = '0;
                        done_next  = 1'b1;
                    end
                end
            end
            ST_EDGE_RD:
            begin
                adj_raddr = from_reg;
            end
            ST_EDGE_WR:
            begin
                if (edge_ok_reg)
                begin
                    adj_we               = 1'b1;
                    valid_next[from_reg] = 1'b1;
                end
                visited_next = '0;
                onpath_next  = '0;
                depth_next   = '0;
            end
            ST_SCAN:
            begin
                if (roots == '0)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    top_next            = root;
                    adj_raddr           = root;
                    stk_we              = 1'b1;
                    stk_wdata           = root;
                    depth_next          = depth_reg + depth_t'(1);
                    visited_next[root]  = 1'b1;
                    onpath_next[root]   = 1'b1;
                end
            end
            ST_EXPAND:
            begin
                if (hit)
                begin
                    done_next     = 1'b1;
                    deadlock_next = 1'b1;
                end
                else if (can_push)
                begin
                    top_next            = child;
                    adj_raddr           = child;
                    stk_we              = 1'b1;
                    depth_next          = depth_reg + depth_t'(1);
                    visited_next[child] = 1'b1;
                    onpath_next[child]  = 1'b1;
                end
                else
                begin
                    // Pop; the stack read for the new top is issued here.
                    onpath_next[top_reg] = 1'b0;
                    depth_next           = depth_reg - depth_t'(1);
                end
            end
            ST_POP_RD:
            begin
                top_next  = stk_rdata;
                adj_raddr = stk_rdata;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            visited_reg  <= '0;
            onpath_reg   <= '0;
            depth_reg    <= '0;
            done_reg     <= 1'b0;
            deadlock_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            visited_reg  <= visited_next;
            onpath_reg   <= onpath_next;
            depth_reg    <= depth_next;
            done_reg     <= done_next;
            deadlock_reg <= deadlock_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg     <= top_next;
        from_reg    <= from_next;
        to_reg      <= to_next;
        edge_ok_reg <= edge_ok_next;
    end

    assign done     = done_reg;
    assign deadlock = deadlock_reg;

    // The result strobe only comes once the walk has handed control back.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while a command is still in progress");

    // Every accepted command either finishes at once or keeps the block busy.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> (done || busy))
        else $error("accepted command produced neither a result nor a busy cycle");

    // The walk never pushes more nodes than exist.
    assert property (@(posedge clk) disable iff (!rst_n) depth_reg <= depth_t'(NODES))
        else $error("walk stack depth exceeds the node count");

    // A push marks the node both visited and on the current path.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXPAND && !hit && can_push)
        |=> (visited_reg[top_reg] && onpath_reg[top_reg]))
        else $error("pushed node not marked visited and on path");

endmodule

`default_nettype wire

// ----- test/tb_lock_order_cycle_detector_top.sv -----
`timescale 1ns / 100ps
// Testbench for lock_order_cycle_detector_top: lock-order edges and clears are sent, and every
// deadlock flag is checked against a graph model kept here. Depends on locd_pkg and the RTL.

module tb_lock_order_cycle_detector_top
    import locd_pkg::*;
();

    // The watchdog limit lies above both the slowest walk from transfer to result and the
    // longest sender gap.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 3 * NODES + 16;
    localparam int MAX_REPORTS    = 200;

    typedef struct packed {
        logic        op;
        node_t       src;
        node_t       dst;
        logic        deadlock;
        int unsigned seq;
    } lock_cmd_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    logic  op;
    node_t from_lock;
    node_t to_lock;
    logic  done;
    logic  deadlock;

    // Row n holds the locks that have been taken while lock n was held.
    node_set_t   order_graph [NODES];
    lock_cmd_t   pending_q [$];
    int unsigned mismatch_count = 0;
    int unsigned cmd_count = 0;
    int          idle_cycles = 0;
    bit          quiet_sender = 1'b0;

    lock_order_cycle_detector_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .from_lock (from_lock),
        .to_lock   (to_lock),
        .done      (done),
        .deadlock  (deadlock)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Peel off every lock with no edge into the remaining set; whatever is left lies on or leads into a cycle.
    function automatic logic graph_has_cycle();
        node_set_t live;
        bit        changed;
        live = '1;
        do
        begin
            changed = 1'b0;
            for (int n = 0; n < NODES; n++)
            begin
                if (live[n] && ((order_graph[n] & live) == '0))
                begin
                    live[n] = 1'b0;
                    changed = 1'b1;
                end
            end
        end
        while (changed);
        return live != '0;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (quiet_sender)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 60);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_cmd(input logic cmd_op, input node_t src, input node_t dst);
        int        gap;
        lock_cmd_t cmd;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        op        <= cmd_op;
        from_lock <= src;
        to_lock   <= dst;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        if (cmd_op == OP_CLEAR)
        begin
            for (int n = 0; n < NODES; n++)
            begin
                order_graph[n] = '0;
            end
        end
        else
        begin
            order_graph[src][dst] = 1'b1;
        end
        cmd.op       = cmd_op;
        cmd.src      = src;
        cmd.dst      = dst;
        cmd.deadlock = (cmd_op == OP_CLEAR) ? 1'b0 : graph_has_cycle();
        cmd.seq      = cmd_count;
        cmd_count++;
        pending_q = {pending_q, cmd};
        @(negedge clk);
    endtask

    task automatic send_clear();
        send_cmd(OP_CLEAR, node_t'($urandom), node_t'($urandom));
    endtask

    task automatic test_clear_empty();
        send_cmd(OP_CLEAR, '0, '0);
        send_cmd(OP_CLEAR, '1, '1);
    endtask

    task automatic test_self_edges();
        send_cmd(OP_ADD, '0, '0);
        send_clear();
        send_cmd(OP_ADD, '1, '1);
        send_clear();
    endtask

    task automatic test_two_lock_cycle();
        send_cmd(OP_ADD, node_t'(0), node_t'(NODES - 1));
        send_cmd(OP_ADD, node_t'(NODES - 1), node_t'(0));
        send_cmd(OP_ADD, node_t'(NODES - 1), node_t'(0));
        send_clear();
    endtask

    task automatic test_duplicate_edge();
        send_cmd(OP_ADD, node_t'(5), node_t'(9));
        send_cmd(OP_ADD, node_t'(5), node_t'(9));
        send_cmd(OP_ADD, node_t'(9), node_t'(12));
        send_clear();
    endtask

    // Two paths join without a cycle; the closing edge then makes one.
    task automatic test_diamond();
        send_cmd(OP_ADD, node_t'(1), node_t'(2));
        send_cmd(OP_ADD, node_t'(1), node_t'(3));
        send_cmd(OP_ADD, node_t'(2), node_t'(4));
        send_cmd(OP_ADD, node_t'(3), node_t'(4));
        send_cmd(OP_ADD, node_t'(4), node_t'(1));
        send_clear();
    endtask

    task automatic send_forward_edge(input int order [NODES], input int span);
        int lo;
        int hi;
        lo = $urandom_range(0, span - 2);
        hi = $urandom_range(lo + 1, span - 1);
        send_cmd(OP_ADD, node_t'(order[lo]), node_t'(order[hi]));
    endtask

    // Each episode builds a consistent lock order along a shuffled chain, so the walk goes
    // deep, and then often closes it with one edge against the order.
    task automatic test_random_lock_orders(input int episodes);
        int order [NODES];
        int span;
        int pick;
        int tmp;
        int lo;
        int hi;
        repeat (episodes)
        begin
            quiet_sender = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < NODES; i++)
            begin
                order[i] = i;
            end
            for (int i = NODES - 1; i > 0; i--)
            begin
                pick        = $urandom_range(0, i);
                tmp         = order[i];
                order[i]    = order[pick];
                order[pick] = tmp;
            end
            span = $urandom_range(2, NODES);
            send_clear();
            for (int i = 0; i < span - 1; i++)
            begin
                send_cmd(OP_ADD, node_t'(order[i]), node_t'(order[i + 1]));
            end
            repeat ($urandom_range(0, 15)) send_forward_edge(order, span);
            if ($urandom_range(0, 1) == 1)
            begin
                lo = $urandom_range(0, span - 1);
                hi = $urandom_range(lo, span - 1);
                send_cmd(OP_ADD, node_t'(order[hi]), node_t'(order[lo]));
            end
            repeat ($urandom_range(0, 3)) send_forward_edge(order, span);
        end
        quiet_sender = 1'b0;
    endtask

    task automatic test_random_noise(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                send_clear();
            end
            else
            begin
                send_cmd(OP_ADD, node_t'($urandom), node_t'($urandom));
            end
        end
    endtask

    always @(posedge clk)
    begin : check_results
        lock_cmd_t oldest;
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
            begin
                report_mismatch($sformatf("deadlock=%0b with no command waiting", deadlock));
            end
            else
            begin
                oldest = pending_q.pop_front();
                if (deadlock !== oldest.deadlock)
                begin
                    report_mismatch($sformatf("cmd %0d op=%0b %0d->%0d: deadlock=%0b, want %0b",
                        oldest.seq, oldest.op, oldest.src, oldest.dst, deadlock,
                        oldest.deadlock));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL lock_order_cycle_detector_top");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        op        = OP_ADD;
        from_lock = '0;
        to_lock   = '0;
        for (int n = 0; n < NODES; n++)
        begin
            order_graph[n] = '0;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_clear_empty();
        test_self_edges();
        test_two_lock_cycle();
        test_duplicate_edge();
        test_diamond();
        test_random_lock_orders(30);
        test_random_noise(270);

        start <= 1'b0;
        while (pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS lock_order_cycle_detector_top");
        end
        else
        begin
            $display("FAIL lock_order_cycle_detector_top");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/locd_pkg.sv
hdl/locd_ram.sv
hdl/lock_order_cycle_detector_top.sv
test/tb_lock_order_cycle_detector_top.sv
